/* hdl/stepper_trapezoid_ramp_gen_macros.svh */
// assertion macros for the stepper ramp generator checker
`ifndef STEPPER_TRAPEZOID_RAMP_GEN_MACROS_SVH
`define STEPPER_TRAPEZOID_RAMP_GEN_MACROS_SVH
// implication checked on every clock while out of reset
`define STR_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// next-cycle implication
`define STR_ASSERT_NXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

/* hdl/str_pkg.sv */
// shared types and constants for the stepper ramp generator
`timescale 1ns / 1ps
package str_pkg;
    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_MOVE = 2'd1;
    localparam logic [1:0] KIND_LIMIT = 2'd2;
    localparam logic [1:0] KIND_ESTOP = 2'd3;
    localparam logic [1:0] REG_MIN_SPEED = 2'd0;
    localparam logic [1:0] REG_ACCEL = 2'd1;
    localparam logic [1:0] REG_RATE = 2'd2;
    localparam logic [15:0] MIN_SPEED_RESET = 16'd50;
    localparam logic [15:0] ACCEL_STEP_RESET = 16'd5;
    localparam logic [31:0] TIMER_RATE_RESET = 32'd100000;
    // packed axis record, 164 bits
    typedef struct packed {
        logic [31:0] position;
        logic [31:0] goal;
        logic [15:0] cur_speed;
        logic [15:0] cruise_speed;
        logic [31:0] interval;
        logic [31:0] tick_count;
        logic        reverse;
        logic        halted;
        logic        step_level;
        logic        dir_level;
    } axis_rec_t;
    localparam int REC_W = $bits(axis_rec_t);
    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_READ, ST_WAIT, ST_MOD, ST_DIV, ST_WRITE, ST_NEXT, ST_OUT
    } state_t;
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [15:0] divisor;
    } div_req_t;
endpackage

/* hdl/str_ram.sv */
// generic ram with one write port and one registered read port
`timescale 1ns / 1ps
module str_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* hdl/str_div.sv */
// serial restoring divider, 32 bit by 16 bit, one quotient bit per cycle
`timescale 1ns / 1ps
module str_div
    import str_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  div_req_t    req,
    output logic        busy,
    output logic [31:0] quotient
);
    logic [31:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [15:0] dsr_reg, dsr_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [32:0] trial;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end
    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        cnt_next = cnt_reg;
        trial = {rem_reg[31:0], quo_reg[31]};
        if (req.start)
        begin
            quo_next = req.dividend;
            rem_next = '0;
            dsr_next = req.divisor;
            cnt_next = 6'd32;
        end
        else if (cnt_reg != 6'd0)
        begin
            cnt_next = cnt_reg - 6'd1;
            if (trial >= {17'd0, dsr_reg})
            begin
                rem_next = trial - {17'd0, dsr_reg};
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[30:0], 1'b0};
            end
        end
    end
    assign busy = (cnt_reg != 6'd0);
    assign quotient = quo_reg;
endmodule

/* hdl/stepper_trapezoid_ramp_gen.sv */
// top level of the multi-axis stepper pulse generator with trapezoidal ramp
//
// s_axis carries one item per transfer: tick, move, limit hit or emergency stop.
// m_axis returns one status word per item: step and direction levels, idle flag.
// cfg writes min_speed (0), accel_step (1), timer_rate (2); the user must write
// them only while idle, the block itself does not enforce it.
// axis records sit in one ram; each item walks the axes one by one: read,
// modify, optional serial divide of timer_rate by speed, write.
// the serial divider and the ram port set the item throughput.
// after reset a clearing pass writes a reset record for each axis; no item
// is taken meanwhile. running and per-axis line levels live only in the ram,
// so step_lines and dir_lines are gathered during the walk.
// the result waits in an output register; the next item is taken only after
// it has been transferred, so a stalled receiver stalls the input.
`timescale 1ns / 1ps
module stepper_trapezoid_ramp_gen
    import str_pkg::*;
#(
    parameter int AXES = 3
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // target_position[31:0], has_position[32], speed[48:33], has_speed[49], zero fill
    input  logic [55:0] s_axis_tdata,
    // kind[1:0], axis[3:2]
    input  logic [3:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // step_lines[2:0], dir_lines[5:3], all_idle[6], zero fill
    output logic [7:0]  m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    localparam int AW = (AXES > 1) ? $clog2(AXES) : 1;
    localparam int RD = (AXES > 1) ? AXES : 2;

    state_t      st_reg, st_next;
    logic [AW-1:0] ax_reg, ax_next;
    logic [1:0]  kind_reg, kind_next;
    logic [1:0]  sel_reg, sel_next;
    logic [49:0] dat_reg, dat_next;
    axis_rec_t   rec_reg, rec_next;
    logic [2:0]  stp_reg, stp_next, dir_reg, dir_next;
    logic        idle_reg, idle_next;
    logic [7:0]  out_reg, out_next;
    logic        ov_reg, ov_next;
    logic [15:0] mins_reg, acc_reg;
    logic [31:0] rate_reg;

    logic        we;
    logic [REC_W-1:0] wdata, rdata;
    div_req_t    dreq;
    logic        dbusy;
    logic [31:0] dquo;

    str_ram #(.WIDTH(REC_W), .DEPTH(RD)) u_ram (
        .clk(clk), .we(we), .waddr(ax_reg), .wdata(wdata),
        .raddr(ax_reg), .rdata(rdata)
    );
    str_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .busy(dbusy), .quotient(dquo));

    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mins_reg <= MIN_SPEED_RESET;
            acc_reg <= ACCEL_STEP_RESET;
            rate_reg <= TIMER_RATE_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_MIN_SPEED: mins_reg <= cfg_data[15:0];
                REG_ACCEL:     acc_reg <= cfg_data[15:0];
                REG_RATE:      rate_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_CLEAR;
            ax_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            ax_reg <= ax_next;
            ov_reg <= ov_next;
        end
    end
    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        sel_reg <= sel_next;
        dat_reg <= dat_next;
        rec_reg <= rec_next;
        stp_reg <= stp_next;
        dir_reg <= dir_next;
        idle_reg <= idle_next;
        out_reg <= out_next;
    end

    // modify step, plus replan helpers
    logic signed [32:0] left;
    logic signed [17:0] vdiff, vs;
    logic [31:0] cnt1;
    axis_rec_t r;
    logic dd;
    logic [15:0] sp;
    logic [15:0] rq;
    logic [AW+1:0] ax_last;

    // position and distance left after a step, taken straight from the ram word
    axis_rec_t rd_rec;
    logic [31:0] pos_step;
    logic signed [32:0] left_step;
    logic [32:0] absleft_step;
    assign rd_rec = rdata;
    assign pos_step = rd_rec.reverse ? rd_rec.position - 32'd1 : rd_rec.position + 32'd1;
    assign left_step = $signed({rd_rec.goal[31], rd_rec.goal})
                     - $signed({pos_step[31], pos_step});
    assign absleft_step = left_step[32] ? 33'(-left_step) : 33'(left_step);

    // brake distance divides a narrow value by accel_step; done serially too would
    // cost another pass, so compare left*accel against the difference instead:
    // left <= floor(d/a) with d >= 0 is the same as left*a <= d
    logic [48:0] lxa;
    assign lxa = absleft_step * {17'd0, acc_reg};

    always_comb
    begin
        st_next = st_reg;
        ax_next = ax_reg;
        kind_next = kind_reg;
        sel_next = sel_reg;
        dat_next = dat_reg;
        rec_next = rec_reg;
        stp_next = stp_reg;
        dir_next = dir_reg;
        idle_next = idle_reg;
        out_next = out_reg;
        ov_next = ov_reg;
        we = 1'b0;
        wdata = rec_reg;
        dreq = '0;
        s_axis_tready = 1'b0;
        r = rdata;
        dd = 1'b0;
        sp = '0;
        rq = '0;
        cnt1 = r.tick_count + 32'd1;
        left = $signed({r.goal[31], r.goal}) - $signed({r.position[31], r.position});
        vdiff = $signed({2'b0, r.cur_speed}) - $signed({2'b0, mins_reg});
        vs = $signed({2'b0, r.cur_speed});
        ax_last = {2'b0, ax_reg};
        if (m_axis_tvalid && m_axis_tready)
        begin
            ov_next = 1'b0;
        end
        case (st_reg)
            ST_CLEAR:
            begin
                we = 1'b1;
                wdata = '0;
                wdata[2] = 1'b1;
                if (ax_last == (AW+2)'(AXES - 1))
                begin
                    ax_next = '0;
                    st_next = ST_IDLE;
                end
                else
                begin
                    ax_next = ax_reg + AW'(1);
                end
            end
            ST_IDLE:
            begin
                s_axis_tready = !ov_reg;
                if (s_axis_tvalid && !ov_reg)
                begin
                    kind_next = s_axis_tuser[1:0];
                    sel_next = s_axis_tuser[3:2];
                    dat_next = s_axis_tdata[49:0];
                    ax_next = '0;
                    stp_next = '0;
                    dir_next = '0;
                    idle_next = 1'b1;
                    st_next = ST_READ;
                end
            end
            ST_READ:
            begin
                st_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                st_next = ST_MOD;
            end
            ST_MOD:
            begin
                r = rdata;
                case (kind_reg)
                    KIND_TICK:
                    begin
                        if (!r.halted && r.interval != 32'd0)
                        begin
                            r.tick_count = cnt1;
                            if (cnt1 >= r.interval)
                            begin
                                r.dir_level = !r.reverse;
                                r.step_level = 1'b1;
                            end
                            if ({1'b0, cnt1} >= {1'b0, r.interval} + 33'd1)
                            begin
                                r.step_level = 1'b0;
                                r.tick_count = '0;
                                r.position = pos_step;
                                if (absleft_step == 33'd0)
                                begin
                                    r.cur_speed = '0;
                                    r.interval = '0;
                                    r.halted = 1'b1;
                                end
                                else
                                begin
                                    if (acc_reg != 16'd0 && !vdiff[17]
                                        && lxa <= {31'd0, vdiff})
                                    begin
                                        if (r.cur_speed > mins_reg)
                                        begin
                                            vs = vs - $signed({2'b0, acc_reg});
                                        end
                                    end
                                    else if (r.cur_speed < r.cruise_speed)
                                    begin
                                        vs = vs + $signed({2'b0, acc_reg});
                                        if (vs > $signed({2'b0, r.cruise_speed}))
                                        begin
                                            vs = $signed({2'b0, r.cruise_speed});
                                        end
                                    end
                                    if (vs < $signed({2'b0, mins_reg}))
                                    begin
                                        vs = $signed({2'b0, mins_reg});
                                    end
                                    r.cur_speed = vs[15:0];
                                    dd = 1'b1;
                                end
                            end
                        end
                    end
                    KIND_MOVE:
                    begin
                        if ({2'b0, ax_reg} == {{AW{1'b0}}, sel_reg} || AW < 2)
                        begin
                            if ({{AW{1'b0}}, sel_reg} == {2'b0, ax_reg})
                            begin
                                if (dat_reg[32])
                                begin
                                    r.goal = dat_reg[31:0];
                                end
                                if (dat_reg[49])
                                begin
                                    rq = dat_reg[48:33];
                                    r.cruise_speed = (rq != 16'd0 && rq < mins_reg)
                                                   ? mins_reg : rq;
                                end
                                left = $signed({r.goal[31], r.goal})
                                     - $signed({r.position[31], r.position});
                                if (r.cruise_speed != 16'd0 && left != 33'sd0)
                                begin
                                    r.reverse = left[32];
                                    r.halted = 1'b0;
                                    if (r.cur_speed == 16'd0)
                                    begin
                                        r.cur_speed = mins_reg;
                                    end
                                    dd = 1'b1;
                                end
                                else
                                begin
                                    r.cur_speed = '0;
                                    r.interval = '0;
                                    r.halted = 1'b1;
                                end
                            end
                        end
                    end
                    KIND_LIMIT:
                    begin
                        if ({{AW{1'b0}}, sel_reg} == {2'b0, ax_reg})
                        begin
                            r.halted = 1'b1;
                            r.cur_speed = '0;
                        end
                    end
                    default:
                    begin
                        r.cruise_speed = '0;
                        r.cur_speed = '0;
                        r.interval = '0;
                        r.halted = 1'b1;
                    end
                endcase
                rec_next = r;
                sp = r.cur_speed;
                if (dd)
                begin
                    if (sp == 16'd0)
                    begin
                        rec_next.interval = '0;
                        st_next = ST_WRITE;
                    end
                    else
                    begin
                        dreq.start = 1'b1;
                        dreq.dividend = rate_reg;
                        dreq.divisor = sp;
                        st_next = ST_DIV;
                    end
                end
                else
                begin
                    st_next = ST_WRITE;
                end
            end
            ST_DIV:
            begin
                if (!dbusy)
                begin
                    rec_next.interval = dquo;
                    st_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                we = 1'b1;
                wdata = rec_reg;
                if (ax_last < 3)
                begin
                    stp_next[ax_last[1:0]] = rec_reg.step_level;
                    dir_next[ax_last[1:0]] = rec_reg.dir_level;
                end
                if (!(rec_reg.cur_speed == 16'd0 && rec_reg.halted))
                begin
                    idle_next = 1'b0;
                end
                st_next = ST_NEXT;
            end
            ST_NEXT:
            begin
                if (ax_last == (AW+2)'(AXES - 1))
                begin
                    st_next = ST_OUT;
                end
                else
                begin
                    ax_next = ax_reg + AW'(1);
                    st_next = ST_READ;
                end
            end
            ST_OUT:
            begin
                out_next = {1'b0, idle_reg, dir_reg, stp_reg};
                ov_next = 1'b1;
                ax_next = '0;
                st_next = ST_IDLE;
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata = out_reg;
endmodule

/* hdl/str_checker.sv */
// port-level checker for the stepper ramp generator, bound to the top level
`timescale 1ns / 1ps
`include "stepper_trapezoid_ramp_gen_macros.svh"
module str_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);
    `STR_ASSERT_IMP(a_no_take_while_full, clk, rst_n, m_axis_tvalid, !s_axis_tready)
    `STR_ASSERT_NXT(a_accept_clears_ready, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `STR_ASSERT_NXT(a_out_holds, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `STR_ASSERT_IMP(a_pad_zero, clk, rst_n, m_axis_tvalid, !m_axis_tdata[7])
endmodule

bind stepper_trapezoid_ramp_gen str_checker u_str_checker (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);

/* tb/tb_stepper_trapezoid_ramp_gen.sv */
// self-checking testbench for the stepper ramp generator: directed and random items
`timescale 1ns / 1ps
module tb_stepper_trapezoid_ramp_gen;
    import str_pkg::*;

    localparam int NAX = 3;
    localparam int WATCHDOG = 20000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic [3:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    stepper_trapezoid_ramp_gen #(.AXES(NAX)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    typedef struct packed {
        logic       all_idle;
        logic [2:0] dir_lines;
        logic [2:0] step_lines;
    } status_t;

    // predictor state
    logic [15:0] p_min;
    logic [15:0] p_accel;
    logic [31:0] p_rate;
    logic [31:0] ax_pos [NAX];
    logic [31:0] ax_goal [NAX];
    logic [15:0] ax_spd [NAX];
    logic [15:0] ax_cruise [NAX];
    logic [31:0] ax_intv [NAX];
    logic [31:0] ax_cnt [NAX];
    logic        ax_rev [NAX];
    logic        ax_halt [NAX];
    logic        ax_step [NAX];
    logic        ax_dir [NAX];

    status_t expected_status [$];
    int errors;
    int mismatches;
    int items_sent;
    int results_seen;
    int steps_seen;
    int idle_cycles;
    int send_idle_pct;
    int recv_stall_pct;

    function automatic logic [31:0] rate_over(input logic [15:0] spd);
        return (spd == 16'd0) ? 32'd0 : p_rate / {16'd0, spd};
    endfunction

    function automatic void replan_axis(input int a);
        longint left;
        longint brake;
        longint v;
        left = longint'($signed(ax_goal[a])) - longint'($signed(ax_pos[a]));
        brake = 0;
        v = longint'(ax_spd[a]);
        if (left < 0)
            left = -left;
        if (left == 0)
        begin
            ax_spd[a] = 16'd0;
            ax_intv[a] = 32'd0;
            ax_halt[a] = 1'b1;
            return;
        end
        if (p_accel != 16'd0)
            brake = (v - longint'(p_min)) / longint'(p_accel);
        if (left <= brake)
        begin
            if (v > longint'(p_min))
                v = v - longint'(p_accel);
        end
        else if (v < longint'(ax_cruise[a]))
        begin
            v = v + longint'(p_accel);
            if (v > longint'(ax_cruise[a]))
                v = longint'(ax_cruise[a]);
        end
        if (v < longint'(p_min))
            v = longint'(p_min);
        ax_spd[a] = v[15:0];
        ax_intv[a] = rate_over(ax_spd[a]);
    endfunction

    function automatic void tick_one(input int a);
        logic [32:0] cnt;
        if (ax_halt[a] || ax_intv[a] == 32'd0)
            return;
        ax_cnt[a] = ax_cnt[a] + 32'd1;
        cnt = {1'b0, ax_cnt[a]};
        if (cnt >= {1'b0, ax_intv[a]})
        begin
            ax_dir[a] = !ax_rev[a];
            ax_step[a] = 1'b1;
        end
        if (cnt >= {1'b0, ax_intv[a]} + 33'd1)
        begin
            ax_step[a] = 1'b0;
            ax_cnt[a] = 32'd0;
            ax_pos[a] = ax_rev[a] ? ax_pos[a] - 32'd1 : ax_pos[a] + 32'd1;
            replan_axis(a);
        end
    endfunction

    function automatic void move_one(input int a, input logic [31:0] tp, input logic hp,
                                     input logic [15:0] sp, input logic hs);
        if (hp)
            ax_goal[a] = tp;
        if (hs)
            ax_cruise[a] = (sp != 16'd0 && sp < p_min) ? p_min : sp;
        if (ax_cruise[a] != 16'd0)
        begin
            if ($signed(ax_pos[a]) < $signed(ax_goal[a]))
                ax_rev[a] = 1'b0;
            else if ($signed(ax_pos[a]) > $signed(ax_goal[a]))
                ax_rev[a] = 1'b1;
            if (ax_pos[a] != ax_goal[a])
            begin
                ax_halt[a] = 1'b0;
                if (ax_spd[a] == 16'd0)
                    ax_spd[a] = p_min;
                ax_intv[a] = rate_over(ax_spd[a]);
                return;
            end
        end
        ax_spd[a] = 16'd0;
        ax_intv[a] = 32'd0;
        ax_halt[a] = 1'b1;
    endfunction

    function automatic status_t apply_item(input logic [1:0] kind, input logic [1:0] ax,
                                           input logic [31:0] tp, input logic hp,
                                           input logic [15:0] sp, input logic hs);
        status_t st;
        case (kind)
            KIND_TICK:
                for (int a = 0; a < NAX; a++)
                    tick_one(a);
            KIND_MOVE:
                if (ax < NAX)
                    move_one(ax, tp, hp, sp, hs);
            KIND_LIMIT:
                if (ax < NAX)
                begin
                    ax_halt[ax] = 1'b1;
                    ax_spd[ax] = 16'd0;
                end
            default:
                for (int a = 0; a < NAX; a++)
                begin
                    ax_cruise[a] = 16'd0;
                    ax_spd[a] = 16'd0;
                    ax_intv[a] = 32'd0;
                    ax_halt[a] = 1'b1;
                end
        endcase
        st.all_idle = 1'b1;
        for (int a = 0; a < NAX; a++)
        begin
            st.step_lines[a] = ax_step[a];
            st.dir_lines[a] = ax_dir[a];
            if (!(ax_spd[a] == 16'd0 && ax_halt[a]))
                st.all_idle = 1'b0;
        end
        return st;
    endfunction

    task automatic send_item(input logic [1:0] kind, input logic [1:0] ax,
                             input logic [31:0] tp, input logic hp,
                             input logic [15:0] sp, input logic hs);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
            @(posedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= {ax, kind};
        s_axis_tdata <= {6'd0, hs, sp, hp, tp};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_status.push_back(apply_item(kind, ax, tp, hp, sp, hs));
        items_sent++;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain;
        while (expected_status.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_MIN_SPEED: p_min = val[15:0];
            REG_ACCEL: p_accel = val[15:0];
            default: p_rate = val;
        endcase
        @(posedge clk);
    endtask

    task automatic set_config(input logic [15:0] mn, input logic [15:0] ac,
                              input logic [31:0] rt);
        drain();
        write_reg(REG_MIN_SPEED, {16'd0, mn});
        write_reg(REG_ACCEL, {16'd0, ac});
        write_reg(REG_RATE, rt);
    endtask

    task automatic ticks(input int n);
        for (int i = 0; i < n; i++)
            send_item(KIND_TICK, 2'd0, 32'd0, 1'b0, 16'd0, 1'b0);
    endtask

    task automatic test_directed;
        send_item(KIND_MOVE, 2'd0, 32'd3, 1'b1, 16'd10, 1'b1);
        send_item(KIND_MOVE, 2'd1, 32'hFFFF_FFFE, 1'b1, 16'hFFFF, 1'b1);
        send_item(KIND_MOVE, 2'd2, 32'h7FFF_FFFF, 1'b1, 16'd0, 1'b1);
        send_item(KIND_MOVE, 2'd3, 32'h8000_0000, 1'b1, 16'd100, 1'b1);
        send_item(KIND_LIMIT, 2'd3, 32'd0, 1'b0, 16'd0, 1'b0);
        ticks(8);
        send_item(KIND_MOVE, 2'd2, 32'd0, 1'b0, 16'd200, 1'b1);
        send_item(KIND_LIMIT, 2'd1, 32'd0, 1'b0, 16'd0, 1'b0);
        ticks(4);
        send_item(KIND_ESTOP, 2'd0, 32'd0, 1'b0, 16'd0, 1'b0);
        send_item(KIND_MOVE, 2'd0, 32'd0, 1'b0, 16'd0, 1'b0);
        ticks(2);
    endtask

    task automatic test_zero_min_and_accel;
        set_config(16'd0, 16'd0, 32'd20);
        send_item(KIND_MOVE, 2'd0, 32'd5, 1'b1, 16'd4, 1'b1);
        send_item(KIND_MOVE, 2'd1, 32'hFFFF_FFF0, 1'b1, 16'd0, 1'b1);
        ticks(20);
    endtask

    task automatic test_random(input int n);
        int k;
        logic [1:0] ax;
        logic [15:0] sp;
        logic [31:0] tp;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(99);
            ax = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2));
            if (k < 70)
                send_item(KIND_TICK, 2'($urandom_range(3)), $urandom, 1'($urandom),
                          16'($urandom), 1'($urandom));
            else if (k < 92)
            begin
                sp = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(400));
                tp = ($urandom_range(9) == 0) ? $urandom
                     : ax_pos[ax < NAX ? ax : 0] + 32'($urandom_range(40)) - 32'd20;
                send_item(KIND_MOVE, ax, tp, ($urandom_range(4) != 0), sp,
                          ($urandom_range(3) != 0));
            end
            else if (k < 98)
                send_item(KIND_LIMIT, ax, $urandom, 1'($urandom), 16'($urandom),
                          1'($urandom));
            else
                send_item(KIND_ESTOP, ax, $urandom, 1'($urandom), 16'($urandom),
                          1'($urandom));
        end
    endtask

    task automatic test_pause_until_empty;
        send_item(KIND_MOVE, 2'd0, ax_pos[0] + 32'd30, 1'b1, 16'd300, 1'b1);
        while (expected_status.size() != 0)
            @(posedge clk);
        ticks(10);
    endtask

    // result checker
    always @(posedge clk)
    begin
        status_t exp_s;
        status_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = status_t'(m_axis_tdata[6:0]);
            results_seen++;
            if (got.step_lines != 3'd0)
                steps_seen++;
            if (expected_status.size() == 0)
            begin
                errors++;
                if (mismatches < 10)
                    $display("unexpected result %h", m_axis_tdata);
                mismatches++;
            end
            else
            begin
                exp_s = expected_status.pop_front();
                if (got !== exp_s || m_axis_tdata[7] !== 1'b0)
                begin
                    errors++;
                    if (mismatches < 10)
                        $display("mismatch: step exp %b got %b, dir exp %b got %b, idle exp %b got %b",
                                 exp_s.step_lines, got.step_lines, exp_s.dir_lines,
                                 got.dir_lines, exp_s.all_idle, got.all_idle);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
            m_axis_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG)
        begin
            $display("stepper_trapezoid_ramp_gen verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b1;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        mismatches = 0;
        items_sent = 0;
        results_seen = 0;
        steps_seen = 0;
        idle_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        p_min = MIN_SPEED_RESET;
        p_accel = ACCEL_STEP_RESET;
        p_rate = TIMER_RATE_RESET;
        for (int a = 0; a < NAX; a++)
        begin
            ax_pos[a] = '0; ax_goal[a] = '0; ax_spd[a] = '0; ax_cruise[a] = '0;
            ax_intv[a] = '0; ax_cnt[a] = '0; ax_rev[a] = 1'b0; ax_halt[a] = 1'b1;
            ax_step[a] = 1'b0; ax_dir[a] = 1'b0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_config(16'd50, 16'd5, 32'd200);
        test_directed();
        test_zero_min_and_accel();
        set_config(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        test_random(40);
        set_config(16'd1, 16'd1, 32'd1);
        test_random(300);
        set_config(16'd20, 16'd7, 32'd600);
        send_idle_pct = 68;
        test_random(400);
        test_pause_until_empty();
        send_idle_pct = 0;
        recv_stall_pct = 68;
        set_config(16'd10, 16'd3, 32'd300);
        test_random(400);
        send_idle_pct = 25;
        recv_stall_pct = 25;
        set_config(16'd5, 16'd50, 32'd1000);
        test_random(400);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        set_config(16'd40, 16'd2, 32'd80);
        test_random(300);
        drain();

        $display("covered %0d items, %0d results, %0d with a step line high",
                 items_sent, results_seen, steps_seen);
        $display("configs swept from extremes, moves, limit hits, estops, idle and stall mixes");
        if (errors == 0 && expected_status.size() == 0)
            $display("stepper_trapezoid_ramp_gen verification clean");
        else
            $display("stepper_trapezoid_ramp_gen verification failed");
        $finish;
    end
endmodule

/* filelist.f */
+incdir+hdl
hdl/str_pkg.sv
hdl/str_ram.sv
hdl/str_div.sv
hdl/stepper_trapezoid_ramp_gen.sv
hdl/str_checker.sv
tb/tb_stepper_trapezoid_ramp_gen.sv
